[rtl/gradient_histogram_accumulator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the gradient histogram accumulator
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_HISTOGRAM_ACCUMULATOR_MACROS_SVH
`define GRADIENT_HISTOGRAM_ACCUMULATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// property holds at every rising clock edge outside reset
`define GHACC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression never true outside reset
`define GHACC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GHACC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GHACC_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/ghacc_pkg.sv]
// ----------------------------------------------------------------------------
// ghacc_pkg
// Shared widths, codes and the saturating add of the histogram accumulator.
// ----------------------------------------------------------------------------
package ghacc_pkg;

	// field widths
	localparam int SLOT_W  = 11;
	localparam int IDX_W   = SLOT_W - 1;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 48;
	localparam int CFG_W   = 11;

	// APB register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BINS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] BINS_RESET = 11'd1024;

	// request codes
	localparam logic REQ_ACC  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// 48-bit sum plus a sign-extended 32-bit value, clamped to the 48-bit range
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] acc,
		input logic signed [VAL_W-1:0] x
	);
		logic signed [SUM_W:0] s;
		s = {acc[SUM_W-1], acc} + {{(SUM_W+1-VAL_W){x[VAL_W-1]}}, x};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		end
		return s[SUM_W-1:0];
	endfunction

endpackage

[rtl/ghacc_if.sv]
// ----------------------------------------------------------------------------
// ghacc request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// request channel: accumulate or read-and-clear one bin
interface ghacc_req_if import ghacc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [SLOT_W-1:0] slot;
	logic signed [VAL_W-1:0]  grad;
	logic signed [VAL_W-1:0]  hess;

	modport source (output valid, req_type, slot, grad, hess, input ready);
	modport sink (input valid, req_type, slot, grad, hess, output ready);
endinterface

// response channel: status and the sums of a read bin
interface ghacc_rsp_if import ghacc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [SUM_W-1:0] grad_sum;
	logic signed [SUM_W-1:0] hess_sum;

	modport source (output valid, status, grad_sum, hess_sum, input ready);
	modport sink (input valid, status, grad_sum, hess_sum, output ready);
endinterface

[rtl/ghacc_ram.sv]
// ----------------------------------------------------------------------------
// ghacc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ghacc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/gradient_histogram_accumulator.sv]
// ----------------------------------------------------------------------------
// gradient_histogram_accumulator
// Per-bin gradient and hessian sums in one RAM, updated read-modify-write.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          contents
//  req       in    valid/ready        req_type, slot, grad, hess
//  rsp       out   valid/ready        status, grad_sum, hess_sum
//  apb       in    psel/penable       bins_in_use at offset 0
//
//  One item per cycle unless rsp stalls; the result register loads from stage 1.
//  The RAM read is issued at acceptance and the write-back lands as the item
//  leaves stage 1; a write register forwards the last written bin to the next item.
//  After reset a clearing pass zeroes every RAM bin, with req.ready low.
//  A stalled rsp holds the result and the item in flight, and req backs up.
// ----------------------------------------------------------------------------
`include "gradient_histogram_accumulator_macros.svh"

module gradient_histogram_accumulator import ghacc_pkg::*; #(
	parameter int MAX_BINS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	ghacc_req_if.sink          req,
	ghacc_rsp_if.source        rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW    = $clog2(MAX_BINS);
	localparam int RAM_W = 2 * SUM_W;

	// configuration
	logic [CFG_W-1:0] bins_q;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// stage 1: item waiting on RAM read data
	logic                    valid_s1;
	logic                    req_type_s1;
	status_t                 status_s1;
	logic [AW-1:0]           addr_s1;
	logic signed [VAL_W-1:0] grad_s1;
	logic signed [VAL_W-1:0] hess_s1;

	// output register
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [SUM_W-1:0] out_grad_q;
	logic signed [SUM_W-1:0] out_hess_q;

	// last RAM write, for forwarding
	logic             fwd_valid_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [RAM_W-1:0] fwd_data_q;

	logic                    accept;
	logic                    advance;
	logic [IDX_W-1:0]        slot_idx;
	logic                    in_range;
	status_t                 in_status;
	logic [AW-1:0]           in_addr;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [RAM_W-1:0]        ram_wdata;
	logic [RAM_W-1:0]        ram_rdata;
	logic [RAM_W-1:0]        old_sums;
	logic signed [SUM_W-1:0] old_grad;
	logic signed [SUM_W-1:0] old_hess;
	logic signed [SUM_W-1:0] new_grad;
	logic signed [SUM_W-1:0] new_hess;
	logic                    item_we;

	// APB register access
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= BINS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_BINS_IN_USE) begin
			bins_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BINS_IN_USE) begin
			prdata = PDATA_W'(bins_q);
		end
	end

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clr_busy_q && (!valid_s1 || advance);
	assign accept    = req.valid && req.ready;

	// slot decode at acceptance
	assign slot_idx = req.slot[IDX_W-1:0];
	assign in_range = ({1'b0, slot_idx} < bins_q) && (32'(slot_idx) < 32'(MAX_BINS));
	assign in_addr  = AW'(slot_idx);

	always_comb begin
		if (req.slot[SLOT_W-1]) begin
			in_status = ST_MISSING;
		end else if (!in_range) begin
			in_status = ST_RANGE;
		end else begin
			in_status = ST_DONE;
		end
	end

	// read-modify-write with forwarding of the previous write
	assign old_sums = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_rdata;
	assign old_grad = old_sums[RAM_W-1:SUM_W];
	assign old_hess = old_sums[SUM_W-1:0];

	always_comb begin
		if (req_type_s1 == REQ_READ) begin
			new_grad = '0;
			new_hess = '0;
		end else begin
			new_grad = sat_add(old_grad, grad_s1);
			new_hess = sat_add(old_hess, hess_s1);
		end
	end

	assign item_we = advance && status_s1 == ST_DONE;

	// RAM write port: clearing pass or item write-back
	assign ram_we    = clr_busy_q || item_we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : {new_grad, new_hess};

	ghacc_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_BINS)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MAX_BINS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			status_s1   <= in_status;
			addr_s1     <= in_addr;
			grad_s1     <= req.grad;
			hess_s1     <= req.hess;
		end
		if (advance) begin
			out_status_q <= status_s1;
			if (status_s1 == ST_DONE && req_type_s1 == REQ_READ) begin
				out_grad_q <= old_grad;
				out_hess_q <= old_hess;
			end else begin
				out_grad_q <= '0;
				out_hess_q <= '0;
			end
		end
		if (ram_we) begin
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.grad_sum = out_grad_q;
	assign rsp.hess_sum = out_hess_q;

	// checks
	`GHACC_NEVER(a_no_accept_in_clear, clk, arst_n, clr_busy_q && accept,
		"item accepted during clearing pass")
	`GHACC_NEVER(a_skip_no_write, clk, arst_n,
		ram_we && !clr_busy_q && status_s1 != ST_DONE, "skipped item wrote the bin store")
	`GHACC_NEVER(a_no_overwrite, clk, arst_n, advance && out_valid_q && !rsp.ready,
		"stalled result overwritten")
	`GHACC_ASSERT(a_skip_zero, clk, arst_n,
		(rsp.valid && rsp.status != ST_DONE) |-> (rsp.grad_sum == '0 && rsp.hess_sum == '0),
		"skipped item returned nonzero sums")

endmodule

[bench/gradient_histogram_accumulator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_histogram_accumulator_test
// Self-checking bench for the gradient histogram accumulator. A queue-fed
// driver pushes accumulate and read-and-clear items, an in-bench bin model
// predicts every result and a monitor checks them in order. The bench
// changes bins_in_use between phases and stalls both channels at random.
// ----------------------------------------------------------------------------
module gradient_histogram_accumulator_test;
	import ghacc_pkg::*;

	localparam int MAX_BINS = 1024;

	typedef struct {
		logic                     req_type;
		logic signed [SLOT_W-1:0] slot;
		logic signed [VAL_W-1:0]  grad;
		logic signed [VAL_W-1:0]  hess;
	} hist_req_t;

	typedef struct {
		status_t                 status;
		logic signed [SUM_W-1:0] grad_sum;
		logic signed [SUM_W-1:0] hess_sum;
	} hist_rsp_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	ghacc_req_if req_ch ();
	ghacc_rsp_if rsp_ch ();

	gradient_histogram_accumulator #(.MAX_BINS(MAX_BINS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// bin model state and configuration
	logic signed [SUM_W-1:0] grad_bins [MAX_BINS];
	logic signed [SUM_W-1:0] hess_bins [MAX_BINS];
	logic [CFG_W-1:0]        bins_cfg;

	hist_req_t item_q[$];
	hist_rsp_t result_q[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	logic req_taken;
	logic hold_go;
	logic hold_rsp;
	int  bin_plan [9];

	int mismatches;
	int items_taken;
	int acc_done;
	int reads_done;
	int missing_seen;
	int range_seen;
	int clamp_hits;
	int results_checked;
	int settings_used;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// queue one item for the driver
	function automatic void add_item(input hist_req_t it);
		item_q.insert(item_q.size(), it);
	endfunction

	// effective number of bins
	function automatic int bin_limit();
		return (int'(bins_cfg) < MAX_BINS) ? int'(bins_cfg) : MAX_BINS;
	endfunction

	// 48-bit sum plus 32-bit value, clamped to the signed 48-bit range
	function automatic logic signed [SUM_W-1:0] clamp_add(
		input logic signed [SUM_W-1:0] acc,
		input logic signed [VAL_W-1:0] x
	);
		logic signed [SUM_W:0] wide;
		wide = (SUM_W+1)'(acc) + (SUM_W+1)'(x);
		if (wide > (SUM_W+1)'(SUM_MAX)) begin
			clamp_hits++;
			return SUM_MAX;
		end
		if (wide < (SUM_W+1)'(SUM_MIN)) begin
			clamp_hits++;
			return SUM_MIN;
		end
		return wide[SUM_W-1:0];
	endfunction

	// apply one item to the bin model and return its result
	function automatic hist_rsp_t bin_update(input hist_req_t it);
		hist_rsp_t r;
		int idx;
		r.status = ST_DONE;
		r.grad_sum = '0;
		r.hess_sum = '0;
		idx = int'(it.slot);
		if (it.slot < 0) begin
			r.status = ST_MISSING;
			missing_seen++;
		end else if (idx >= bin_limit()) begin
			r.status = ST_RANGE;
			range_seen++;
		end else if (it.req_type == REQ_ACC) begin
			grad_bins[idx] = clamp_add(grad_bins[idx], it.grad);
			hess_bins[idx] = clamp_add(hess_bins[idx], it.hess);
			acc_done++;
		end else begin
			r.grad_sum = grad_bins[idx];
			r.hess_sum = hess_bins[idx];
			grad_bins[idx] = '0;
			hess_bins[idx] = '0;
			reads_done++;
		end
		return r;
	endfunction

	function automatic hist_req_t mk(input logic rt, input int slot, input int g, input int h);
		hist_req_t it;
		it.req_type = rt;
		it.slot = slot[SLOT_W-1:0];
		it.grad = g;
		it.hess = h;
		return it;
	endfunction

	// gradient or hessian: full range, small, extremes, or up to 64 units in 16.16
	function automatic logic signed [VAL_W-1:0] random_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 20) - (1 << 19);
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(0, 1 << 23) - (1 << 22);
		endcase
	endfunction

	// mostly valid accumulates and reads over a few hot bins, some noise
	function automatic hist_req_t random_item();
		hist_req_t it;
		logic [31:0] raw;
		int lim;
		int pick;
		int hot;
		lim = bin_limit();
		pick = $urandom_range(0, 99);
		raw = $urandom;
		hot = (lim < 8) ? lim : 8;
		it.req_type = raw[31];
		it.slot = raw[SLOT_W-1:0];
		it.grad = random_value();
		it.hess = random_value();
		if (pick < 80) begin
			it.req_type = (pick < 60) ? REQ_ACC : REQ_READ;
			if (lim > 0) begin
				if (raw[20])
					it.slot = SLOT_W'($urandom_range(0, hot - 1));
				else
					it.slot = SLOT_W'($urandom_range(0, lim - 1));
			end
		end else if (pick < 88) begin
			it.slot[SLOT_W-1] = 1'b1;
		end else if (pick < 95) begin
			if (lim < MAX_BINS)
				it.slot = SLOT_W'($urandom_range(lim, MAX_BINS - 1));
		end
		return it;
	endfunction

	// accept side: predict on every accepted item
	always @(posedge clk) begin
		hist_rsp_t predicted;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predicted = bin_update(hist_req_t'{req_ch.req_type, req_ch.slot,
				req_ch.grad, req_ch.hess});
			result_q.insert(result_q.size(), predicted);
			items_taken++;
			req_taken <= 1'b1;
		end else begin
			req_taken <= 1'b0;
		end
	end

	// driver: offer the next queued item unless idling
	always @(negedge clk) begin
		hist_req_t nxt;
		logic offer;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			offer = req_ch.valid && !req_taken;
			if (!offer && item_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = item_q.pop_front();
				offer = 1'b1;
				req_ch.req_type <= nxt.req_type;
				req_ch.slot <= nxt.slot;
				req_ch.grad <= nxt.grad;
				req_ch.hess <= nxt.hess;
			end
			req_ch.valid <= offer;
		end
	end

	// receiver: random stalls plus the long hold-off
	always @(negedge clk) begin
		rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		hold_rsp = 1'b0;
		wait (hold_go);
		hold_rsp = 1'b1;
		repeat (300) @(posedge clk);
		hold_rsp = 1'b0;
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		hist_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (result_q.size() == 0) begin
				note_mismatch($sformatf("result with no item pending: status %0d", rsp_ch.status));
			end else begin
				want = result_q.pop_front();
				results_checked++;
				if (rsp_ch.status !== want.status || rsp_ch.grad_sum !== want.grad_sum ||
				    rsp_ch.hess_sum !== want.hess_sum)
					note_mismatch($sformatf(
						"status %0d/%0d grad_sum %0d/%0d hess_sum %0d/%0d (exp/got)",
						want.status, rsp_ch.status, want.grad_sum, rsp_ch.grad_sum,
						want.hess_sum, rsp_ch.hess_sum));
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
	                          output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_BINS_IN_USE, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every queued item is out and every result is back
	task automatic drain();
		while (item_q.size() > 0 || req_ch.valid || result_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write bins_in_use while idle, read it back
	task automatic set_bins(input logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		drain();
		apb_access(1'b1, PDATA_W'(value), rd);
		apb_access(1'b0, '0, rd);
		if (rd !== PDATA_W'(value))
			note_mismatch($sformatf("bins_in_use readback %0d, wrote %0d", rd, value));
		bins_cfg = value;
		settings_used++;
	endtask

	// stimulus
	initial begin
		logic [PDATA_W-1:0] rd;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_ACC;
		req_ch.slot = '0;
		req_ch.grad = '0;
		req_ch.hess = '0;
		rsp_ch.ready = 1'b0;
		req_taken = 1'b0;
		hold_go = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 56;
		bins_cfg = BINS_RESET;
		for (int i = 0; i < MAX_BINS; i++) begin
			grad_bins[i] = '0;
			hess_bins[i] = '0;
		end
		bin_plan = '{1024, 37, 2, 1000, 2047, 0, 1, 512, 1024};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register comes up at its reset value
		apb_access(1'b0, '0, rd);
		if (rd !== PDATA_W'(BINS_RESET))
			note_mismatch($sformatf("bins_in_use after reset %0d", rd));

		// directed: extremes, both requests, missing and out-of-range slots
		add_item(mk(REQ_ACC, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_item(mk(REQ_ACC, 0, 32'h8000_0000, 32'h8000_0000));
		add_item(mk(REQ_READ, 0, 0, 0));
		add_item(mk(REQ_READ, 0, 32'h1234_5678, 32'h0000_0001));
		add_item(mk(REQ_ACC, 1023, 32'h8000_0000, 32'h7FFF_FFFF));
		add_item(mk(REQ_READ, 1023, 0, 0));
		add_item(mk(REQ_ACC, -1, 32'h0001_0000, 32'h0001_0000));
		add_item(mk(REQ_READ, -1, 0, 0));
		add_item(mk(REQ_READ, -1024, 0, 0));
		// back-to-back updates of one bin exercise forwarding
		repeat (3) add_item(mk(REQ_ACC, 5, 32'h0001_0000, 32'h0000_8000));
		add_item(mk(REQ_READ, 5, 0, 0));
		add_item(mk(REQ_ACC, 7, -3, 32'h0002_0000));
		add_item(mk(REQ_READ, 7, 0, 0));
		add_item(mk(REQ_ACC, 7, -1, -1));
		add_item(mk(REQ_READ, 7, 0, 0));
		// single bin: slot 1 is out of range
		set_bins(11'd1);
		add_item(mk(REQ_ACC, 0, 32'h0000_4000, 32'h0000_2000));
		add_item(mk(REQ_ACC, 1, 32'h0000_4000, 32'h0000_2000));
		add_item(mk(REQ_READ, 1, 0, 0));
		add_item(mk(REQ_READ, 0, 0, 0));
		// no bins: every non-negative slot out of range
		set_bins(11'd0);
		add_item(mk(REQ_ACC, 0, 1, 1));
		add_item(mk(REQ_READ, -1, 0, 0));
		// above the store depth the limit is the depth
		set_bins(11'd2047);
		add_item(mk(REQ_ACC, 1023, 32'h0003_0000, -5));
		add_item(mk(REQ_READ, 1023, 0, 0));

		// random phases, one bins_in_use setting each
		for (int p = 0; p < 9; p++) begin
			set_bins(bin_plan[p][CFG_W-1:0]);
			if (p < 3) begin
				send_idle_pct = 15;
				recv_idle_pct = 56;
			end else if (p < 6) begin
				send_idle_pct = 56;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (150) add_item(random_item());
			if (p == 1)
				hold_go = 1'b1;
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Checked %0d results of %0d items over %0d bins_in_use settings.",
			results_checked, items_taken, settings_used);
		$display("%0d accumulates, %0d reads, %0d missing, %0d out of range, %0d clamps.",
			acc_done, reads_done, missing_seen, range_seen, clamp_hits);
		if (mismatches == 0 && result_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[gradient_histogram_accumulator.f]
+incdir+rtl
rtl/ghacc_pkg.sv
rtl/ghacc_if.sv
rtl/ghacc_ram.sv
rtl/gradient_histogram_accumulator.sv
bench/gradient_histogram_accumulator_test.sv
